// ----- hdl/xoshiro256ss_prng_splitmix_seed_unit_macros.svh -----
// Assertion helpers shared by the generator RTL.
`ifndef XOSHIRO256SS_PRNG_SPLITMIX_SEED_UNIT_MACROS_SVH
`define XOSHIRO256SS_PRNG_SPLITMIX_SEED_UNIT_MACROS_SVH

// Same-cycle implication, switched off while reset is asserted.
`define XSS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("xss assertion failed");

// Next-cycle implication, switched off while reset is asserted.
`define XSS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("xss assertion failed");

`endif

// ----- hdl/xss_pkg.sv -----
`default_nettype none

package xss_pkg;

    localparam int WORD_W      = 64;
    localparam int NUM_WORDS   = 4;
    localparam int WIDX_W      = $clog2(NUM_WORDS);
    localparam int QUEUE_DEPTH = 2;

    // splitmix64 constants
    localparam logic [WORD_W-1:0] GOLDEN_STEP = 64'h9e3779b97f4a7c15;
    localparam logic [WORD_W-1:0] MIX_MUL_A   = 64'hbf58476d1ce4e5b9;
    localparam logic [WORD_W-1:0] MIX_MUL_B   = 64'h94d049bb133111eb;
    localparam int MIX_SHIFT_0 = 30;
    localparam int MIX_SHIFT_1 = 27;
    localparam int MIX_SHIFT_2 = 31;

    // xoshiro256** constants
    localparam int SHIFT_T = 17;
    localparam int ROT_W3  = 45;
    localparam int ROT_OUT = 7;

    // queued operation codes
    localparam logic OP_DRAW = 1'b0;
    localparam logic OP_SEED = 1'b1;

    typedef struct packed {
        logic              op;
        logic [WORD_W-1:0] seed;
    } xss_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } xss_qstat_t;

    // rotate left by a constant amount in 1..63
    function automatic logic [WORD_W-1:0] rotl64(input logic [WORD_W-1:0] v,
                                                 input int unsigned k);
        return (v << k) | (v >> (WORD_W - k));
    endfunction

endpackage

`default_nettype wire

// ----- hdl/xss_front.sv -----
`default_nettype none

module xss_front
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic                  cmd,
    input  wire logic [63:0]           seed_value,
    input  wire xss_pkg::xss_qstat_t   qstat,
    output logic                       push,
    output xss_pkg::xss_entry_t        push_entry
);

    logic                 valid_reg;
    logic                 valid_next;
    xss_pkg::xss_entry_t  entry_reg;
    logic                 accept;

    assign in_stall   = valid_reg && qstat.full;
    assign accept     = in_valid && !in_stall;
    assign push       = valid_reg && !qstat.full;
    assign push_entry = entry_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (push)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // decode the command into a queue operation
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            entry_reg.op   <= cmd ? xss_pkg::OP_SEED : xss_pkg::OP_DRAW;
            entry_reg.seed <= seed_value;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/xss_queue.sv -----
`default_nettype none

`include "xoshiro256ss_prng_splitmix_seed_unit_macros.svh"

module xss_queue
#(
    parameter int DEPTH = xss_pkg::QUEUE_DEPTH
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  push,
    input  wire xss_pkg::xss_entry_t   push_entry,
    input  wire logic                  pop,
    output xss_pkg::xss_entry_t        head,
    output xss_pkg::xss_qstat_t        qstat
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL = CW'(DEPTH);

    xss_pkg::xss_entry_t entries_reg [DEPTH];

    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW-1:0] rd_ptr_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;

    assign head        = entries_reg[rd_ptr_reg];
    assign qstat.full  = (count_reg == FULL);
    assign qstat.empty = (count_reg == '0);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_entry;
        end
    end

    `XSS_ASSERT_NEXT(a_q_pop_only, clk, rst_n, pop && !push, count_reg == $past(count_reg) - 1'b1)
    `XSS_ASSERT_NEXT(a_q_push_only, clk, rst_n, push && !pop, count_reg == $past(count_reg) + 1'b1)

endmodule

`default_nettype wire

// ----- hdl/xss_back.sv -----
`default_nettype none

`include "xoshiro256ss_prng_splitmix_seed_unit_macros.svh"

module xss_back
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire xss_pkg::xss_qstat_t   qstat,
    input  wire xss_pkg::xss_entry_t   head,
    output logic                       pop,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic [63:0]                random_value
);

    localparam int WW = xss_pkg::WORD_W;
    localparam int NW = xss_pkg::NUM_WORDS;
    localparam int IW = xss_pkg::WIDX_W;

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_SEED_ADD = 3'd1;
    localparam logic [2:0] ST_MUL_A    = 3'd2;
    localparam logic [2:0] ST_XS       = 3'd3;
    localparam logic [2:0] ST_MUL_B    = 3'd4;
    localparam logic [2:0] ST_STORE    = 3'd5;
    localparam logic [2:0] ST_DRAW     = 3'd6;

    // partial product phases of a 64 x 64 (low half) multiply
    localparam logic [1:0] P0 = 2'd0;
    localparam logic [1:0] P1 = 2'd1;
    localparam logic [1:0] P2 = 2'd2;

    logic [2:0]    state_reg;
    logic [2:0]    state_next;
    logic [1:0]    phase_reg;
    logic [1:0]    phase_next;
    logic [IW-1:0] word_reg;
    logic [IW-1:0] word_next;
    logic          out_valid_reg;
    logic          out_valid_next;
    logic [WW-1:0] words_reg [NW];
    logic [WW-1:0] words_next [NW];

    logic [WW-1:0] acc_reg;
    logic [WW-1:0] acc_next;
    logic [WW-1:0] mz_reg;
    logic [WW-1:0] mz_next;
    logic [WW-1:0] prod_reg;
    logic [WW-1:0] prod_next;
    logic [WW-1:0] rot_reg;
    logic [WW-1:0] rot_next;
    logic [WW-1:0] out_data_reg;
    logic [WW-1:0] out_data_next;

    logic [WW-1:0] acc_sum;
    logic [31:0]   mul_a;
    logic [31:0]   mul_b;
    logic [WW-1:0] mul_k;
    logic [WW-1:0] mul_p;
    logic [WW-1:0] prod_step;
    logic [WW-1:0] times5;
    logic [WW-1:0] upd2;
    logic [WW-1:0] upd3;
    logic          out_free;

    assign out_valid    = out_valid_reg;
    assign random_value = out_data_reg;
    assign out_free     = !out_valid_reg || !out_stall;
    assign pop          = (state_reg == ST_IDLE) && !qstat.empty;

    assign acc_sum = acc_reg + xss_pkg::GOLDEN_STEP;

    // one shared 32 x 32 multiplier, three passes per 64-bit product
    assign mul_a     = (phase_reg == P2) ? mz_reg[63:32] : mz_reg[31:0];
    assign mul_k     = (state_reg == ST_MUL_B) ? xss_pkg::MIX_MUL_B : xss_pkg::MIX_MUL_A;
    assign mul_b     = (phase_reg == P1) ? mul_k[63:32] : mul_k[31:0];
    assign mul_p     = {32'd0, mul_a} * {32'd0, mul_b};
    assign prod_step = (phase_reg == P0) ? mul_p
                                         : {prod_reg[63:32] + mul_p[31:0], prod_reg[31:0]};

    // output and state advance terms
    assign times5 = words_reg[1] + (words_reg[1] << 2);
    assign upd2   = words_reg[2] ^ words_reg[0];
    assign upd3   = words_reg[3] ^ words_reg[1];

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        word_next      = word_reg;
        acc_next       = acc_reg;
        mz_next        = mz_reg;
        prod_next      = prod_reg;
        rot_next       = rot_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && out_stall;
        for (int i = 0; i < NW; i++)
        begin
            words_next[i] = words_reg[i];
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (!qstat.empty)
                begin
                    if (head.op == xss_pkg::OP_SEED)
                    begin
                        acc_next   = head.seed;
                        word_next  = '0;
                        state_next = ST_SEED_ADD;
                    end
                    else
                    begin
                        rot_next      = xss_pkg::rotl64(times5, xss_pkg::ROT_OUT);
                        words_next[2] = upd2 ^ (words_reg[1] << xss_pkg::SHIFT_T);
                        words_next[1] = words_reg[1] ^ upd2;
                        words_next[0] = words_reg[0] ^ upd3;
                        words_next[3] = xss_pkg::rotl64(upd3, xss_pkg::ROT_W3);
                        state_next    = ST_DRAW;
                    end
                end
            end
            ST_DRAW:
            begin
                if (out_free)
                begin
                    out_data_next  = rot_reg + (rot_reg << 3);
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_SEED_ADD:
            begin
                acc_next   = acc_sum;
                mz_next    = acc_sum ^ (acc_sum >> xss_pkg::MIX_SHIFT_0);
                phase_next = P0;
                state_next = ST_MUL_A;
            end
            ST_MUL_A:
            begin
                prod_next = prod_step;
                if (phase_reg == P2)
                begin
                    phase_next = P0;
                    state_next = ST_XS;
                end
                else
                begin
                    phase_next = phase_reg + 1'b1;
                end
            end
            ST_XS:
            begin
                mz_next    = prod_reg ^ (prod_reg >> xss_pkg::MIX_SHIFT_1);
                phase_next = P0;
                state_next = ST_MUL_B;
            end
            ST_MUL_B:
            begin
                prod_next = prod_step;
                if (phase_reg == P2)
                begin
                    phase_next = P0;
                    state_next = ST_STORE;
                end
                else
                begin
                    phase_next = phase_reg + 1'b1;
                end
            end
            ST_STORE:
            begin
                words_next[word_reg] = prod_reg ^ (prod_reg >> xss_pkg::MIX_SHIFT_2);
                word_next            = word_reg + 1'b1;
                state_next           = (&word_reg) ? ST_IDLE : ST_SEED_ADD;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= P0;
            word_reg      <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NW; i++)
            begin
                words_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            word_reg      <= word_next;
            out_valid_reg <= out_valid_next;
            for (int i = 0; i < NW; i++)
            begin
                words_reg[i] <= words_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg      <= acc_next;
        mz_reg       <= mz_next;
        prod_reg     <= prod_next;
        rot_reg      <= rot_next;
        out_data_reg <= out_data_next;
    end

    `XSS_ASSERT_IMPLY(a_out_from_draw, clk, rst_n, $rose(out_valid_reg), $past(state_reg) == ST_DRAW)
    `XSS_ASSERT_NEXT(a_seed_ends, clk, rst_n, state_reg == ST_STORE && (&word_reg), state_reg == ST_IDLE)
    `XSS_ASSERT_NEXT(a_mul_a_ends, clk, rst_n, state_reg == ST_MUL_A && phase_reg == P2, state_reg == ST_XS)

endmodule

`default_nettype wire

// ----- hdl/xoshiro256ss_prng_splitmix_seed_unit.sv -----
// xoshiro256** generator with splitmix64 seeding. A transaction with cmd = 0 returns the next
// 64-bit value and advances the four state words; cmd = 1 reseeds from seed_value and returns
// nothing. Until the first reseed the state is all zero and every draw returns zero. A front
// register decodes each transaction into a short queue; the back end executes it. The back
// end takes the next transaction only once it is through with the last, and a draw holds it
// in the draw state while the output register is stalled. A reseed runs splitmix64 for each
// of the four words: two 64-bit multiplies per word, each done as three 32 x 32 partial
// products on one shared multiplier. Transactions keep arriving into the queue while a reseed
// runs, until the queue and the front register are full. A draw passes through the front
// register, the queue, the back end's draw state and the output register before it is presented.
`default_nettype none

module xoshiro256ss_prng_splitmix_seed_unit
#(
    parameter int QDEPTH = xss_pkg::QUEUE_DEPTH
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    // input transactions
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        cmd,
    input  wire logic [63:0] seed_value,

    // result transactions
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [63:0]      random_value
);

    xss_pkg::xss_qstat_t q_stat;
    xss_pkg::xss_entry_t push_entry;
    xss_pkg::xss_entry_t head_entry;
    logic                push;
    logic                pop;

    // front: input register and command decode
    xss_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .cmd        (cmd),
        .seed_value (seed_value),
        .qstat      (q_stat),
        .push       (push),
        .push_entry (push_entry)
    );

    // decoupling queue between decode and execution
    xss_queue #(
        .DEPTH (QDEPTH)
    ) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head_entry),
        .qstat      (q_stat)
    );

    // back: generator state, seeding sequencer and output register
    xss_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .qstat        (q_stat),
        .head         (head_entry),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .random_value (random_value)
    );

endmodule

`default_nettype wire

// ----- bench/xoshiro256ss_prng_splitmix_seed_unit_tb.sv -----
`timescale 1ns / 100ps

module xoshiro256ss_prng_splitmix_seed_unit_tb;

    // splitmix64 and xoshiro256** constants, kept local so that the bench
    // does not lean on the package values it is meant to check
    localparam logic [63:0] SM_GOLDEN = 64'h9e3779b97f4a7c15;
    localparam logic [63:0] SM_MUL_A  = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] SM_MUL_B  = 64'h94d049bb133111eb;
    localparam int unsigned XS_SHIFT  = 17;
    localparam int unsigned XS_ROT_W3 = 45;
    localparam int unsigned XS_ROT_OUT = 7;

    localparam int RANDOM_TXNS  = 450;
    localparam int DRAIN_CYCLES = 80;   // covers a reseed still running in the back end
    localparam int MAX_REPORTS  = 10;

    // one pending input transaction
    typedef struct packed {
        logic        op;
        logic [63:0] seed;
    } gen_txn_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;

    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        cmd = xss_pkg::OP_DRAW;
    logic [63:0] seed_value = '0;

    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [63:0] random_value;

    // transactions waiting to be offered, and draws waiting to come back
    gen_txn_t    pending_txns[$];
    logic [63:0] expected_draws[$];

    // shadow copy of the four generator words
    logic [63:0] gen_words[4];

    int          fail_count = 0;

    // sender burst/gap bookkeeping
    int          burst_left = 0;
    int          gap_left = 0;

    // receiver stall pattern: a stall level held for a random stretch
    int          stall_level = 0;
    int          stall_stretch = 0;

    xoshiro256ss_prng_splitmix_seed_unit dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .cmd          (cmd),
        .seed_value   (seed_value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .random_value (random_value)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Generator prediction
    // ------------------------------------------------------------------

    function automatic logic [63:0] rol64(input logic [63:0] v, input int unsigned n);
        return (v << n) | (v >> (64 - n));
    endfunction

    // splitmix64: each word takes the running value plus the golden step,
    // mixed by two multiply-xorshift rounds and a closing xorshift
    function automatic void splitmix_reseed(input logic [63:0] seed);
        logic [63:0] acc;
        logic [63:0] z;
        acc = seed;
        for (int w = 0; w < 4; w++)
        begin
            acc = acc + SM_GOLDEN;
            z = acc;
            z = (z ^ (z >> 30)) * SM_MUL_A;
            z = (z ^ (z >> 27)) * SM_MUL_B;
            gen_words[w] = z ^ (z >> 31);
        end
    endfunction

    // xoshiro256** output from the current state, then the state advance
    function automatic logic [63:0] xoshiro_next();
        logic [63:0] draw;
        logic [63:0] t;
        draw = rol64(gen_words[1] * 64'd5, XS_ROT_OUT) * 64'd9;
        t = gen_words[1] << XS_SHIFT;
        gen_words[2] = gen_words[2] ^ gen_words[0];
        gen_words[3] = gen_words[3] ^ gen_words[1];
        gen_words[1] = gen_words[1] ^ gen_words[2];
        gen_words[0] = gen_words[0] ^ gen_words[3];
        gen_words[2] = gen_words[2] ^ t;
        gen_words[3] = rol64(gen_words[3], XS_ROT_W3);
        return draw;
    endfunction

    // ------------------------------------------------------------------
    // Driver: offers queued transactions in bursts of random length with
    // random gaps in between. A stalled transaction is held unchanged.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        gen_txn_t next_txn;
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            cmd        <= xss_pkg::OP_DRAW;
            seed_value <= '0;
            burst_left <= 0;
            gap_left   <= 0;
        end
        else if (!in_valid || !in_stall)
        begin
            // slot is free: nothing on offer, or the last transaction was taken
            if (gap_left != 0)
            begin
                gap_left <= gap_left - 1;
                in_valid <= 1'b0;
            end
            else if (pending_txns.size() != 0)
            begin
                next_txn   = pending_txns.pop_front();
                in_valid   <= 1'b1;
                cmd        <= next_txn.op;
                seed_value <= next_txn.seed;
                if (burst_left <= 1)
                begin
                    // end of burst: a third of bursts run straight on
                    burst_left <= $urandom_range(1, 16);
                    gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
                end
                else
                begin
                    burst_left <= burst_left - 1;
                end
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: follows accepted input transactions through the predictor,
    // checks each accepted result against the oldest expected draw, and
    // drives the receiver stall.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        logic [63:0] want;
        if (!rst_n)
        begin
            for (int w = 0; w < 4; w++)
                gen_words[w] = '0;
            out_stall     <= 1'b0;
            stall_level   <= 0;
            stall_stretch <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                if (cmd == xss_pkg::OP_SEED)
                    splitmix_reseed(seed_value);
                else
                    expected_draws.push_back(xoshiro_next());
            end

            if (out_valid && !out_stall)
            begin
                if (expected_draws.size() == 0)
                begin
                    fail_count = fail_count + 1;
                    if (fail_count <= MAX_REPORTS)
                        $display("%0t: unexpected result %h", $realtime, random_value);
                end
                else
                begin
                    want = expected_draws.pop_front();
                    if (random_value !== want)
                    begin
                        fail_count = fail_count + 1;
                        if (fail_count <= MAX_REPORTS)
                            $display("%0t: random_value expected %h got %h",
                                     $realtime, want, random_value);
                    end
                end
            end

            // level 0 never stalls; level 3 stalls about three quarters of the time
            if (stall_stretch == 0)
            begin
                stall_level   <= $urandom_range(0, 3);
                stall_stretch <= $urandom_range(10, 80);
                out_stall     <= 1'b0;
            end
            else
            begin
                stall_stretch <= stall_stretch - 1;
                out_stall     <= ($urandom_range(0, 3) < stall_level);
            end
        end
    end

    task automatic queue_txn(input logic op, input logic [63:0] seed);
        gen_txn_t t;
        t.op = op;
        t.seed = seed;
        pending_txns.push_back(t);
    endtask

    function automatic logic [63:0] pick_seed();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return 64'd1 << $urandom_range(0, 63);
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial
    begin
        // never seeded: the all-zero state is a fixed point, draws give zero,
        // and the seed field must be ignored on a draw
        queue_txn(xss_pkg::OP_DRAW, '0);
        queue_txn(xss_pkg::OP_DRAW, '1);
        queue_txn(xss_pkg::OP_DRAW, 64'h8000_0000_0000_0001);

        // extreme seeds
        queue_txn(xss_pkg::OP_SEED, '0);
        queue_txn(xss_pkg::OP_DRAW, '1);
        queue_txn(xss_pkg::OP_DRAW, '0);
        queue_txn(xss_pkg::OP_SEED, '1);
        queue_txn(xss_pkg::OP_DRAW, '0);
        queue_txn(xss_pkg::OP_DRAW, '1);
        queue_txn(xss_pkg::OP_DRAW, 64'h5555_5555_5555_5555);

        // back-to-back reseeds, where only the later one counts, then a reseed after a draw
        queue_txn(xss_pkg::OP_SEED, 64'd1);
        queue_txn(xss_pkg::OP_SEED, 64'h8000_0000_0000_0000);
        queue_txn(xss_pkg::OP_DRAW, 64'hAAAA_AAAA_AAAA_AAAA);
        queue_txn(xss_pkg::OP_SEED, 64'h0123_4567_89AB_CDEF);
        queue_txn(xss_pkg::OP_DRAW, '0);
        queue_txn(xss_pkg::OP_DRAW, '0);
        queue_txn(xss_pkg::OP_DRAW, '0);
        queue_txn(xss_pkg::OP_DRAW, '0);

        // random part: long runs of draws broken by the odd reseed
        for (int i = 0; i < RANDOM_TXNS; i++)
        begin
            if ($urandom_range(0, 9) == 0)
                queue_txn(xss_pkg::OP_SEED, pick_seed());
            else
                queue_txn(xss_pkg::OP_DRAW, {$urandom, $urandom});
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_txns.size() != 0 || in_valid)
            @(negedge clk);
        while (expected_draws.size() != 0)
            @(negedge clk);
        // a trailing reseed may still be running; let any stray result show
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (fail_count == 0 && expected_draws.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial
    begin
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
